// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSHA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define SSHA_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("%m failed");
`else
`define SSHA_ASSERT(lbl, clk, rstn, prop)
`define SSHA_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== rtl/ssha_pkg.sv =====
// Shared constants and types for the segment/sphere hit accumulator.
// No dependencies.
package ssha_pkg;
    localparam int MAX_SPHERES_DEF = 1024;
    localparam int COORD_BITS_DEF  = 16;
    localparam int WORTH_W  = 16;
    localparam int REACH_W  = 16;
    localparam int MARGIN_W = 16;
    localparam int TOTAL_W  = 32;
    localparam int HITS_W   = 11;
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_WAYPOINT = 1'b1;

    typedef struct packed {
        logic valid;
        logic visited;
    } ssha_rd_tag_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } ssha_hit_tag_t;
endpackage

// ===== rtl/ssha_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ssha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/ssha_dist.sv =====
// Six-stage point-to-segment distance test for one sphere per cycle.
// Depends on ssha_pkg.
module ssha_dist
    import ssha_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int AW = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ssha_rd_tag_t        in_tag,
    input  logic [AW-1:0]       in_addr,
    input  logic [3*CB-1:0]     centre,
    input  logic [WORTH_W-1:0]  worth,
    input  logic [REACH_W-1:0]  reach,
    input  logic [3*CB-1:0]     pt_a,
    input  logic [3*CB-1:0]     pt_b,
    input  logic [MARGIN_W-1:0] margin,
    output ssha_hit_tag_t       out_tag,
    output logic [AW-1:0]       out_addr,
    output logic [WORTH_W-1:0]  out_worth,
    output logic                busy
);
    localparam int DW = CB + 1;
    localparam int RW = REACH_W + 1;
    localparam int NW = (2 * DW + 2 > 2 * RW) ? 2 * DW + 2 : 2 * RW;
    localparam int H  = (NW + 1) / 2;
    localparam int NS = 6;

    logic               v_q   [NS];
    logic [AW-1:0]      adr_q [NS];
    logic [WORTH_W-1:0] wr_q  [NS];

    // stage 1
    logic signed [DW-1:0] pa_reg [3], pb_reg [3], d_reg [3];
    logic signed [DW-1:0] pa_next [3], pb_next [3], d_next [3];
    logic [RW-1:0] rr_reg, rr_next;
    logic          sk1_reg;
    // stage 2
    logic [2*DW-1:0]        sqa_reg [3], sqb_reg [3], sqd_reg [3];
    logic signed [2*DW-1:0] pr_reg [3];
    logic [2*RW-1:0]        r2_reg;
    logic                   sk2_reg;
    // stage 3
    logic [NW-1:0]        na_reg, nb_reg, len_reg, r2w_reg;
    logic signed [NW-1:0] dot_reg;
    logic                 sk3_reg;
    logic [NW-1:0]        na_next, nb_next, len_next;
    logic signed [NW-1:0] dot_next;
    // stage 4
    logic [NW-1:0] e_reg, l_reg, q_reg;
    logic          hit0_reg, chk_reg;
    logic          endp, inr;
    // stage 5
    logic [2*H-1:0] pe_reg [4], pq_reg [4];
    logic           hit0b_reg, chkb_reg;
    logic [H-1:0]   e_p [2], l_p [2], q_p [2];
    // stage 6
    logic [4*H-1:0] se, sq;
    logic           hit6_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa_next[k] = DW'($signed(centre[k*CB +: CB])) - DW'($signed(pt_a[k*CB +: CB]));
            pb_next[k] = DW'($signed(centre[k*CB +: CB])) - DW'($signed(pt_b[k*CB +: CB]));
            d_next[k]  = DW'($signed(pt_b[k*CB +: CB])) - DW'($signed(pt_a[k*CB +: CB]));
        end
        rr_next = RW'(reach) + RW'(margin);
        na_next  = NW'(sqa_reg[0]) + NW'(sqa_reg[1]) + NW'(sqa_reg[2]);
        nb_next  = NW'(sqb_reg[0]) + NW'(sqb_reg[1]) + NW'(sqb_reg[2]);
        len_next = NW'(sqd_reg[0]) + NW'(sqd_reg[1]) + NW'(sqd_reg[2]);
        dot_next = NW'(pr_reg[0]) + NW'(pr_reg[1]) + NW'(pr_reg[2]);
        endp = (na_reg <= r2w_reg) || (nb_reg <= r2w_reg);
        inr  = (len_reg != '0) && !dot_reg[NW-1] && (NW'(dot_reg) <= len_reg);
        e_p[0] = e_reg[H-1:0];
        e_p[1] = H'(e_reg[NW-1:H]);
        l_p[0] = l_reg[H-1:0];
        l_p[1] = H'(l_reg[NW-1:H]);
        q_p[0] = q_reg[H-1:0];
        q_p[1] = H'(q_reg[NW-1:H]);
        se = ((4*H)'(pe_reg[3]) << (2*H)) + ((4*H)'(pe_reg[2]) << H)
           + ((4*H)'(pe_reg[1]) << H) + (4*H)'(pe_reg[0]);
        sq = ((4*H)'(pq_reg[3]) << (2*H)) + ((4*H)'(pq_reg[2]) << H)
           + ((4*H)'(pq_reg[1]) << H) + (4*H)'(pq_reg[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                v_q[s] <= 1'b0;
            end
        end
        else
        begin
            v_q[0] <= in_tag.valid;
            for (int s = 1; s < NS; s++)
            begin
                v_q[s] <= v_q[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        adr_q[0] <= in_addr;
        wr_q[0]  <= worth;
        for (int s = 1; s < NS; s++)
        begin
            adr_q[s] <= adr_q[s-1];
            wr_q[s]  <= wr_q[s-1];
        end
        for (int k = 0; k < 3; k++)
        begin
            pa_reg[k]  <= pa_next[k];
            pb_reg[k]  <= pb_next[k];
            d_reg[k]   <= d_next[k];
            sqa_reg[k] <= (2*DW)'(pa_reg[k] * pa_reg[k]);
            sqb_reg[k] <= (2*DW)'(pb_reg[k] * pb_reg[k]);
            sqd_reg[k] <= (2*DW)'(d_reg[k] * d_reg[k]);
            pr_reg[k]  <= d_reg[k] * pa_reg[k];
        end
        rr_reg  <= rr_next;
        sk1_reg <= in_tag.visited;
        r2_reg  <= rr_reg * rr_reg;
        sk2_reg <= sk1_reg;
        na_reg  <= na_next;
        nb_reg  <= nb_next;
        len_reg <= len_next;
        dot_reg <= dot_next;
        r2w_reg <= NW'(r2_reg);
        sk3_reg <= sk2_reg;
        e_reg    <= na_reg - r2w_reg;
        l_reg    <= len_reg;
        q_reg    <= NW'(dot_reg);
        hit0_reg <= v_q[2] && !sk3_reg && endp;
        chk_reg  <= v_q[2] && !sk3_reg && !endp && inr;
        pe_reg[0] <= e_p[0] * l_p[0];
        pe_reg[1] <= e_p[0] * l_p[1];
        pe_reg[2] <= e_p[1] * l_p[0];
        pe_reg[3] <= e_p[1] * l_p[1];
        pq_reg[0] <= q_p[0] * q_p[0];
        pq_reg[1] <= q_p[0] * q_p[1];
        pq_reg[2] <= q_p[1] * q_p[0];
        pq_reg[3] <= q_p[1] * q_p[1];
        hit0b_reg <= hit0_reg;
        chkb_reg  <= chk_reg;
        hit6_reg  <= hit0b_reg || (chkb_reg && (se <= sq));
    end

    assign out_tag.valid = v_q[NS-1];
    assign out_tag.hit   = v_q[NS-1] && hit6_reg;
    assign out_addr      = adr_q[NS-1];
    assign out_worth     = wr_q[NS-1];

    always_comb
    begin
        busy = 1'b0;
        for (int s = 0; s < NS; s++)
        begin
            busy = busy | v_q[s];
        end
    end
endmodule

// ===== rtl/segment_sphere_hit_accumulator.sv =====
// Top level of the segment/sphere hit accumulator.
// Depends on ssha_pkg, ssha_ram, ssha_dist and assert_macros.svh.
//
// A load word (tuser 0) stores one sphere and answers in the cycle after it is taken; a
// waypoint word (tuser 1) scans the sphere table, one entry per cycle through the table
// RAM read port, then waits out the RAM read, the six-stage distance pipeline and the
// finish; on an empty table it answers in the cycle after it is taken. One word is
// processed at a time; a new word is taken only while idle with the output register free.
// The user must write margin on the cfg port while idle; the block does not enforce it.
`include "assert_macros.svh"
module segment_sphere_hit_accumulator
    import ssha_pkg::*;
#(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    localparam int IN_W = ((3 * COORD_BITS + WORTH_W + REACH_W + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,  // pos_x, pos_y, pos_z, worth, reach
    input  logic                s_tuser,  // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,  // total, hits
    output logic                m_tuser,  // table_full
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MARGIN_W-1:0] cfg_data
);
    localparam int CB   = COORD_BITS;
    localparam int AW   = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNTW = $clog2(MAX_SPHERES + 1);
    localparam int EW   = 3 * CB + WORTH_W + REACH_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next, idx_reg, idx_next;
    logic [3*CB-1:0]     last_reg, last_next, cur_reg, cur_next;
    logic [TOTAL_W-1:0]  sum_reg, sum_next;
    logic [HITS_W-1:0]   hits_reg, hits_next;
    logic [MARGIN_W-1:0] margin_reg;
    logic                rdv_reg, rdv_next;
    logic [AW-1:0]       rda_reg;
    logic                ov_reg, ov_next, ofull_reg, ofull_next;
    logic [TOTAL_W-1:0]  otot_reg, otot_next;
    logic [HITS_W-1:0]   ohits_reg, ohits_next;

    logic                accept, slot_free;
    logic [3*CB-1:0]     in_pt;
    logic                e_we, v_we, v_wd;
    logic [AW-1:0]       v_wa, raddr;
    logic [EW-1:0]       e_rd;
    logic [0:0]          v_rd;
    ssha_rd_tag_t        rtag;
    ssha_hit_tag_t       htag;
    logic [AW-1:0]       haddr;
    logic [WORTH_W-1:0]  hworth;
    logic                busy;
    logic [TOTAL_W:0]    sum_add;

    assign in_pt     = s_tdata[3*CB-1:0];
    assign slot_free = !ov_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign e_we  = accept && (s_tuser == OP_LOAD) && (cnt_reg != CNTW'(MAX_SPHERES));
    assign v_we  = e_we || htag.hit;
    assign v_wa  = e_we ? cnt_reg[AW-1:0] : haddr;
    assign v_wd  = !e_we;
    assign raddr = idx_reg[AW-1:0];

    ssha_ram #(.WIDTH(EW), .DEPTH(MAX_SPHERES)) u_entry (
        .clk   (clk),
        .we    (e_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (s_tdata[EW-1:0]),
        .raddr (raddr),
        .rdata (e_rd)
    );

    ssha_ram #(.WIDTH(1), .DEPTH(MAX_SPHERES)) u_visited (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_wa),
        .wdata (v_wd),
        .raddr (raddr),
        .rdata (v_rd)
    );

    assign rtag.valid   = rdv_reg;
    assign rtag.visited = v_rd[0];

    ssha_dist #(.CB(CB), .AW(AW)) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (rtag),
        .in_addr   (rda_reg),
        .centre    (e_rd[3*CB-1:0]),
        .worth     (e_rd[3*CB +: WORTH_W]),
        .reach     (e_rd[3*CB+WORTH_W +: REACH_W]),
        .pt_a      (last_reg),
        .pt_b      (cur_reg),
        .margin    (margin_reg),
        .out_tag   (htag),
        .out_addr  (haddr),
        .out_worth (hworth),
        .busy      (busy)
    );

    assign sum_add = {1'b0, sum_reg} + (TOTAL_W + 1)'(hworth);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        cur_next   = cur_reg;
        sum_next   = sum_reg;
        hits_next  = hits_reg;
        rdv_next   = 1'b0;
        ov_next    = ov_reg && !m_tready;
        ofull_next = ofull_reg;
        otot_next  = otot_reg;
        ohits_next = ohits_reg;
        if (htag.hit)
        begin
            sum_next = sum_add[TOTAL_W] ? '1 : sum_add[TOTAL_W-1:0];
            if (hits_reg != '1)
            begin
                hits_next = hits_reg + 1'b1;
            end
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == OP_LOAD)
                    begin
                        ov_next    = 1'b1;
                        ofull_next = !e_we;
                        otot_next  = sum_reg;
                        ohits_next = '0;
                        if (e_we)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        ov_next    = 1'b1;
                        ofull_next = 1'b0;
                        otot_next  = sum_reg;
                        ohits_next = '0;
                        last_next  = in_pt;
                    end
                    else
                    begin
                        cur_next   = in_pt;
                        idx_next   = '0;
                        hits_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rdv_next = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == cnt_reg - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rdv_reg && !busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ofull_next = 1'b0;
                    otot_next  = sum_reg;
                    ohits_next = hits_reg;
                    last_next  = cur_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            last_reg   <= '0;
            sum_reg    <= '0;
            hits_reg   <= '0;
            margin_reg <= '0;
            rdv_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            sum_reg   <= sum_next;
            hits_reg  <= hits_next;
            rdv_reg   <= rdv_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                margin_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        rda_reg   <= raddr;
        ofull_reg <= ofull_next;
        otot_reg  <= otot_next;
        ohits_reg <= ohits_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {5'b0, ohits_reg, otot_reg};
    assign m_tuser  = ofull_reg;

    `SSHA_NEVER(a_hit_idle, clk, rst_n, htag.hit && (state_reg == ST_IDLE))
    `SSHA_NEVER(a_cnt_range, clk, rst_n, cnt_reg > CNTW'(MAX_SPHERES))
    `SSHA_ASSERT(a_full_nohit, clk, rst_n, (m_tvalid && m_tuser) |-> (ohits_reg == '0))
    `SSHA_ASSERT(a_scan_bound, clk, rst_n, (state_reg == ST_SCAN) |-> (idx_reg < cnt_reg))
endmodule

// ===== tb/tb_segment_sphere_hit_accumulator.sv =====
// Testbench for segment_sphere_hit_accumulator: sphere loads, waypoint scans and margin writes,
// checked word by word against a behavioral predictor of the hit scan.
// Depends on ssha_pkg and the RTL of the block.
`timescale 1ns / 100ps
module tb_segment_sphere_hit_accumulator;
    import ssha_pkg::*;

    localparam int TABLE_N = MAX_SPHERES_DEF;
    localparam int STALL_LIMIT = 8000;

    typedef struct {
        logic [31:0] total;
        logic [10:0] hits;
        logic        full;
    } hit_word_t;

    typedef struct {
        logic        op;
        logic [15:0] px, py, pz, worth, reach;
        bit          known;
        logic [31:0] total;
        logic [10:0] hits;
        logic        full;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // pos_x, pos_y, pos_z, worth, reach
    logic        s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // total, hits
    logic        m_tuser;   // table_full
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // predictor state
    shortint     ctr_x[TABLE_N];
    shortint     ctr_y[TABLE_N];
    shortint     ctr_z[TABLE_N];
    int unsigned sph_worth[TABLE_N];
    int unsigned sph_reach[TABLE_N];
    bit          sph_seen[TABLE_N];
    int          sph_count;
    shortint     prev_pt[3];
    logic [31:0] sum_acc;
    int unsigned margin_val;

    hit_word_t   hit_q[$];
    int          fail_cnt;
    int          rx_wait;
    bit          quiet;
    int          idle_cycles;

    segment_sphere_hit_accumulator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic bit seg_hit(shortint ax, shortint ay, shortint az,
                                   shortint bx, shortint by, shortint bz,
                                   shortint cx, shortint cy, shortint cz,
                                   longint unsigned r2);
        longint pa[3], pb[3], dv[3];
        longint unsigned na, nb, len;
        longint dot;
        bit [127:0] lhs, rhs;
        pa[0] = cx - ax; pa[1] = cy - ay; pa[2] = cz - az;
        pb[0] = cx - bx; pb[1] = cy - by; pb[2] = cz - bz;
        dv[0] = bx - ax; dv[1] = by - ay; dv[2] = bz - az;
        na = 0; nb = 0; len = 0; dot = 0;
        for (int k = 0; k < 3; k++)
        begin
            na  += pa[k] * pa[k];
            nb  += pb[k] * pb[k];
            len += dv[k] * dv[k];
            dot += dv[k] * pa[k];
        end
        if (na <= r2 || nb <= r2)
            return 1'b1;
        if (len == 0 || dot < 0 || longint'(dot) > longint'(len))
            return 1'b0;
        lhs = 128'(na) * 128'(len);
        rhs = 128'(r2) * 128'(len) + 128'(dot) * 128'(dot);
        return lhs <= rhs;
    endfunction

    function automatic hit_word_t predict_word(logic op, logic [15:0] px, logic [15:0] py,
                                               logic [15:0] pz, logic [15:0] w,
                                               logic [15:0] r);
        hit_word_t res;
        longint unsigned rr;
        res.hits = 0;
        res.full = 1'b0;
        if (op == OP_LOAD)
        begin
            if (sph_count < TABLE_N)
            begin
                ctr_x[sph_count] = px;
                ctr_y[sph_count] = py;
                ctr_z[sph_count] = pz;
                sph_worth[sph_count] = w;
                sph_reach[sph_count] = r;
                sph_seen[sph_count] = 1'b0;
                sph_count++;
            end
            else
                res.full = 1'b1;
        end
        else
        begin
            for (int i = 0; i < sph_count; i++)
            begin
                rr = sph_reach[i] + margin_val;
                if (!sph_seen[i] && seg_hit(prev_pt[0], prev_pt[1], prev_pt[2],
                        px, py, pz, ctr_x[i], ctr_y[i], ctr_z[i], rr * rr))
                begin
                    sph_seen[i] = 1'b1;
                    if (res.hits < 2047)
                        res.hits++;
                    if (sum_acc > 32'hffff_ffff - sph_worth[i])
                        sum_acc = 32'hffff_ffff;
                    else
                        sum_acc += sph_worth[i];
                end
            end
            prev_pt[0] = px;
            prev_pt[1] = py;
            prev_pt[2] = pz;
        end
        res.total = sum_acc;
        return res;
    endfunction

    // sends one word; returns the predicted result
    task automatic send_word(logic op, logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                             logic [15:0] w, logic [15:0] r, output hit_word_t res);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {r, w, pz, py, px};
        do @(posedge clk); while (!s_tready);
        res = predict_word(op, px, py, pz, w, r);
        hit_q.insert(hit_q.size(), res);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (hit_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_margin(logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        margin_val = v;
    endtask

    function automatic logic [15:0] near_coord(shortint base);
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'(base + $urandom_range(0, 400) - 200);
    endfunction

    function automatic logic [15:0] pick_reach();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 120));
    endfunction

    task automatic random_items(int n);
        hit_word_t res;
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 4)
                send_word(OP_LOAD, near_coord(prev_pt[0]), near_coord(prev_pt[1]),
                          near_coord(prev_pt[2]), 16'($urandom), pick_reach(), res);
            else
                send_word(OP_WAYPOINT, near_coord(prev_pt[0]), near_coord(prev_pt[1]),
                          near_coord(prev_pt[2]), 16'($urandom), 16'($urandom), res);
        end
        quiet = 1'b0;
    endtask

    // output side: checks each word and draws the next stall
    always @(posedge clk)
    begin
        hit_word_t want;
        int        nxt;
        if (rst_n)
        begin
            nxt = rx_wait;
            if (m_tvalid && m_tready)
            begin
                if (hit_q.size() == 0)
                begin
                    $display("%0t: unexpected word total=%0d hits=%0d full=%0b", $time,
                             m_tdata[31:0], m_tdata[42:32], m_tuser);
                    fail_cnt++;
                end
                else
                begin
                    want = hit_q.pop_front();
                    if (m_tdata[31:0] !== want.total)
                    begin
                        $display("%0t: total expected %0d actual %0d", $time, want.total,
                                 m_tdata[31:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[42:32] !== want.hits)
                    begin
                        $display("%0t: hits expected %0d actual %0d", $time, want.hits,
                                 m_tdata[42:32]);
                        fail_cnt++;
                    end
                    if (m_tuser !== want.full)
                    begin
                        $display("%0t: table_full expected %0b actual %0b", $time, want.full,
                                 m_tuser);
                        fail_cnt++;
                    end
                end
                nxt = quiet ? 0 : $urandom_range(0, 15);
            end
            if (nxt > 0)
            begin
                m_tready <= 1'b0;
                rx_wait = nxt - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_wait = 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress, %0d words outstanding", $time, hit_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    dir_row_t dir_rows[] = '{
        '{OP_WAYPOINT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1, 32'd0, 11'd0, 1'b0},
        '{OP_LOAD, 16'd10, 16'd0, 16'd0, 16'd5, 16'd0, 1, 32'd0, 11'd0, 1'b0},
        '{OP_WAYPOINT, 16'd20, 16'd0, 16'd0, 16'd0, 16'd0, 1, 32'd5, 11'd1, 1'b0},
        '{OP_WAYPOINT, 16'd20, 16'd0, 16'd0, 16'd0, 16'd0, 1, 32'd5, 11'd0, 1'b0},
        '{OP_LOAD, 16'd20, 16'd0, 16'd0, 16'hffff, 16'd0, 1, 32'd5, 11'd0, 1'b0},
        '{OP_WAYPOINT, 16'd20, 16'd0, 16'd0, 16'd0, 16'd0, 1, 32'd65540, 11'd1, 1'b0},
        '{OP_LOAD, 16'h8000, 16'h8000, 16'h8000, 16'd0, 16'hffff, 0, 0, 0, 0},
        '{OP_LOAD, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'd0, 0, 0, 0, 0},
        '{OP_LOAD, 16'h7fff, 16'h8000, 16'd0, 16'd1, 16'd3, 0, 0, 0, 0},
        '{OP_WAYPOINT, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'hffff, 0, 0, 0, 0},
        '{OP_WAYPOINT, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 16'd0, 0, 0, 0, 0},
        '{OP_WAYPOINT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0},
        '{OP_LOAD, 16'd50, 16'd50, 16'd0, 16'd7, 16'd49, 0, 0, 0, 0},
        '{OP_LOAD, 16'd60, 16'd50, 16'd0, 16'd9, 16'd50, 0, 0, 0, 0},
        '{OP_LOAD, 16'hff38, 16'd10, 16'd0, 16'd11, 16'd20, 0, 0, 0, 0},
        '{OP_WAYPOINT, 16'd120, 16'd0, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0},
        '{OP_WAYPOINT, 16'hff9c, 16'd0, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0}
    };

    initial
    begin
        hit_word_t res;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LOAD;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        fail_cnt = 0;
        rx_wait = 0;
        quiet = 1'b0;
        idle_cycles = 0;
        sph_count = 0;
        prev_pt = '{0, 0, 0};
        sum_acc = 0;
        margin_val = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_margin(16'd0);
        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].op, dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz,
                      dir_rows[i].worth, dir_rows[i].reach, res);
            if (dir_rows[i].known && (res.total !== dir_rows[i].total ||
                    res.hits !== dir_rows[i].hits || res.full !== dir_rows[i].full))
            begin
                $display("%0t: row %0d expected %0d/%0d/%0b predicted %0d/%0d/%0b", $time, i,
                         dir_rows[i].total, dir_rows[i].hits, dir_rows[i].full,
                         res.total, res.hits, res.full);
                fail_cnt++;
            end
        end

        write_margin(16'hffff);
        random_items(140);
        write_margin(16'($urandom_range(0, 300)));
        random_items(150);
        drain();
        random_items(140);
        write_margin(16'($urandom));
        random_items(140);

        // fill the table, then overflow it
        write_margin(16'd0);
        quiet = 1'b1;
        while (sph_count < TABLE_N)
            send_word(OP_LOAD, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), pick_reach(), res);
        quiet = 1'b0;
        repeat (4)
            send_word(OP_LOAD, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), res);
        send_word(OP_WAYPOINT, 16'($urandom), 16'($urandom), 16'($urandom), 16'd0, 16'd0, res);
        write_margin(16'hffff);
        send_word(OP_WAYPOINT, 16'($urandom), 16'($urandom), 16'($urandom), 16'd0, 16'd0, res);
        send_word(OP_LOAD, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, res);

        drain();
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
